FILE: rtl/fractal_value_noise_height_assert.svh
// Assertion macros for the fractal value noise height block.
// Depends on nothing; included by the top level.
`ifndef FRACTAL_VALUE_NOISE_HEIGHT_ASSERT_SVH
`define FRACTAL_VALUE_NOISE_HEIGHT_ASSERT_SVH
// implication under reset
`define FVN_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) else $error(msg);
// next-cycle implication under reset
`define FVN_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) else $error(msg);
`endif

FILE: rtl/fvnh_pkg.sv
// Package for the fractal value noise height block: widths, Q constants, hash.
// No dependencies.
package fvnh_pkg;
  localparam int CoordBits = 24;
  localparam int FracBits  = 16;
  localparam int QW        = CoordBits + 4 + FracBits; // noise coordinate width
  localparam int IW        = QW - FracBits;            // lattice integer width
  localparam logic [FracBits:0] OneQ = 1 << FracBits;
  localparam longint Recip320 = ((64'sd1 << (FracBits + 16)) + 160) / 320;
  localparam int WOct0 = (6 * (1 << FracBits) + 5) / 10;
  localparam int WOct1 = (1 << FracBits) / 4;
  localparam int WOct2 = ((1 << FracBits) + 5) / 10;
  localparam int WOct3 = ((1 << FracBits) + 10) / 20;
  localparam int Q055  = (11 * (1 << FracBits) + 10) / 20;
  localparam int Q07   = (7 * (1 << FracBits) + 5) / 10;
  localparam int SeaLevel = 62;
  localparam logic [0:0] RegSeed = 1'b0;
  localparam logic [0:0] RegMode = 1'b1;

  // first half of the lattice hash: linear mix and fold
  function automatic logic [31:0] hash_mix(logic [31:0] x, logic [31:0] z, logic [31:0] s);
    logic [31:0] h;
    h = x * 32'd1619 + z * 32'd31337 + s * 32'h9E3779B9;
    return h ^ (h >> 16);
  endfunction

  // second half: multiply and fold, low 16 bits give the lattice value
  function automatic logic [15:0] hash_fin(logic [31:0] h);
    logic [31:0] m;
    m = h * 32'h045d9f3b;
    m = m ^ (m >> 16);
    return m[15:0];
  endfunction
endpackage

FILE: rtl/fvnh_noise.sv
// One pipelined 2D value noise lane with an enable.
// Depends on fvnh_pkg.
module fvnh_noise import fvnh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [QW-1:0]  qx_i,
  input  logic signed [QW-1:0]  qz_i,
  input  logic [31:0]           seed_i,
  output logic [FracBits:0]     val_o
);
  localparam int FW = FracBits;
  // stage 1: split, t^2, first hash half
  logic [31:0] h1_q [4];
  logic [FW-1:0] tx1_q, tz1_q;
  logic [FW:0] tx2_q, tz2_q;
  logic [IW-1:0] x0, z0, x1, z1;
  assign x0 = qx_i[QW-1:FW];
  assign z0 = qz_i[QW-1:FW];
  assign x1 = x0 + IW'(1);
  assign z1 = z0 + IW'(1);
  logic [2*FW-1:0] sqx, sqz;
  assign sqx = qx_i[FW-1:0] * qx_i[FW-1:0];
  assign sqz = qz_i[FW-1:0] * qz_i[FW-1:0];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h1_q[0] <= hash_mix(32'(signed'(x0)), 32'(signed'(z0)), seed_i);
      h1_q[1] <= hash_mix(32'(signed'(x1)), 32'(signed'(z0)), seed_i);
      h1_q[2] <= hash_mix(32'(signed'(x0)), 32'(signed'(z1)), seed_i);
      h1_q[3] <= hash_mix(32'(signed'(x1)), 32'(signed'(z1)), seed_i);
      tx1_q <= qx_i[FW-1:0];
      tz1_q <= qz_i[FW-1:0];
      tx2_q <= {1'b0, sqx[2*FW-1:FW]};
      tz2_q <= {1'b0, sqz[2*FW-1:FW]};
    end
  end
  // stage 2: smoothstep, hash finish
  logic [FW:0] v2_q [4];
  logic [FW:0] fx2_q, fz2_q;
  logic [FW+2:0] kx, kz;
  logic [2*FW+3:0] px, pz;
  assign kx = {OneQ, 1'b0} + OneQ - {1'b0, tx1_q, 1'b0};
  assign kz = {OneQ, 1'b0} + OneQ - {1'b0, tz1_q, 1'b0};
  assign px = tx2_q * kx;
  assign pz = tz2_q * kz;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) v2_q[i] <= {1'b0, hash_fin(h1_q[i]) >> (16 - FW)};
      fx2_q <= px[2*FW:FW];
      fz2_q <= pz[2*FW:FW];
    end
  end
  // stage 3: x products
  logic signed [2*FW+3:0] pa3_q, pb3_q;
  logic [FW:0] a3_q, b3_q, fz3_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa3_q <= $signed({1'b0, fx2_q}) * ($signed({1'b0, v2_q[1]}) - $signed({1'b0, v2_q[0]}));
      pb3_q <= $signed({1'b0, fx2_q}) * ($signed({1'b0, v2_q[3]}) - $signed({1'b0, v2_q[2]}));
      a3_q <= v2_q[0];
      b3_q <= v2_q[2];
      fz3_q <= fz2_q;
    end
  end
  // stage 4: x lerps, result stays between the two corners
  logic [FW:0] a4_q, b4_q, fz4_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a4_q <= (FW+1)'(a3_q) + (FW+1)'(pa3_q >>> FW);
      b4_q <= (FW+1)'(b3_q) + (FW+1)'(pb3_q >>> FW);
      fz4_q <= fz3_q;
    end
  end
  // stage 5: z product
  logic signed [2*FW+3:0] pc5_q;
  logic [FW:0] a5_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pc5_q <= $signed({1'b0, fz4_q}) * ($signed({1'b0, b4_q}) - $signed({1'b0, a4_q}));
      a5_q <= a4_q;
    end
  end
  // stage 6: z lerp
  logic [FW:0] val_q;
  always_ff @(posedge clk_i) begin
    if (en_i) val_q <= (FW+1)'(a5_q) + (FW+1)'(pc5_q >>> FW);
  end
  assign val_o = val_q;
endmodule

FILE: rtl/fractal_value_noise_height.sv
// Fractal value noise height: 4 octaves plus a continent octave, five noise lanes.
// Registers: stage 0, lanes, stages 7-8, output; one transaction per cycle unless stalled.
// Throughput set by the fully pipelined lanes; back pressure stalls the whole pipe.
// Reset (async, active low) clears valid bits, seed to 0 and natural mode to 1.
// Depends on fvnh_pkg, fvnh_noise and fractal_value_noise_height_assert.svh.
`include "fractal_value_noise_height_assert.svh"
module fractal_value_noise_height import fvnh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // world_x[23:0], world_z[47:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // top_height[6:0], shore[7]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  localparam int FW = FracBits;
  localparam int Lat = 10;
  logic [31:0] seed_q;
  logic        nat_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      nat_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegSeed: seed_q <= cfg_data_i;
        RegMode: nat_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipe advances when the output slot is free or being taken
  logic en;
  logic [Lat-1:0] vld_q;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
  end
  assign m_axis_tvalid = vld_q[Lat-1];

  // stage 0: register coordinates, continent scaling product (reciprocal is 24 bits)
  logic signed [CoordBits-1:0] x0_q, z0_q;
  logic signed [CoordBits+24:0] cxp_q, czp_q;
  logic signed [CoordBits-1:0] xin, zin;
  assign xin = s_axis_tdata[CoordBits-1:0];
  assign zin = s_axis_tdata[2*CoordBits-1:CoordBits];
  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= xin;
      z0_q <= zin;
      cxp_q <= xin * $signed({1'b0, 24'(Recip320)});
      czp_q <= zin * $signed({1'b0, 24'(Recip320)});
    end
  end

  // octave coordinates: coordinate shifted by FRAC_BITS-6+k
  logic [FW:0] nv [5];
  logic signed [QW-1:0] cx, cz;
  assign cx = QW'(cxp_q >>> 16);
  assign cz = QW'(czp_q >>> 16);
  for (genvar k = 0; k < 4; k++) begin : g_oct
    fvnh_noise u_oct (
      .clk_i, .en_i(en),
      .qx_i(QW'(x0_q) <<< (FW - 6 + k)),
      .qz_i(QW'(z0_q) <<< (FW - 6 + k)),
      .seed_i(seed_q), .val_o(nv[k])
    );
  end
  fvnh_noise u_cont (
    .clk_i, .en_i(en), .qx_i(cx), .qz_i(cz),
    .seed_i(seed_q + 32'd101), .val_o(nv[4])
  );

  // stage 7: weighted products and continent offset
  logic [2*FW+1:0] wp_q [4];
  logic signed [FW+2:0] e_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      wp_q[0] <= nv[0] * (FW+1)'(WOct0);
      wp_q[1] <= nv[1] * (FW+1)'(WOct1);
      wp_q[2] <= nv[2] * (FW+1)'(WOct2);
      wp_q[3] <= nv[3] * (FW+1)'(WOct3);
      e_q <= $signed({2'b0, nv[4]} << 1) - $signed((FW+3)'(Q055));
    end
  end
  // stage 8: sum and damping
  logic [FW+1:0] h_q;
  logic signed [FW+2:0] ed_q;
  logic [2*FW+3:0] acc;
  logic signed [2*FW+4:0] dp;
  assign acc = wp_q[0] + wp_q[1] + wp_q[2] + wp_q[3];
  assign dp = e_q * $signed({1'b0, (FW+1)'(Q07)});
  always_ff @(posedge clk_i) begin
    if (en) begin
      h_q <= acc[2*FW+1:FW];
      ed_q <= e_q[FW+2] ? (FW+3)'(dp >>> FW) : e_q;
    end
  end
  // stage 9: combine, clamp, shore flag
  logic signed [FW+9:0] t;
  logic signed [9:0] off, top;
  logic [FW+6:0] fl;
  logic [6:0] res;
  always_comb begin
    t = ed_q * 10'sd26 + ($signed({8'b0, h_q}) - $signed((FW+10)'(OneQ >> 1))) * 10'sd20;
    off = t[FW+9] ? -10'(( -t) >>> FW) : 10'(t >>> FW);
    top = 10'(SeaLevel) + off;
    if (top < 10'sd8) top = 10'sd8;
    if (top > 10'sd120) top = 10'sd120;
    fl = h_q * 5'd24;
    res = nat_q ? top[6:0] : 7'(7'd60 + 7'(fl >> FW));
  end
  logic [7:0] out_q;
  always_ff @(posedge clk_i) begin
    if (en) out_q <= {res <= 7'(SeaLevel + 1), res};
  end
  assign m_axis_tdata = out_q;

  `FVN_ASSERT_NXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed under stall")
  `FVN_ASSERT_IMP(a_ready_rule, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready mismatch")
  `FVN_ASSERT_IMP(a_range, m_axis_tvalid && nat_q, m_axis_tdata[6:0] >= 7'd8 && m_axis_tdata[6:0] <= 7'd120, "height out of range")
endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the fractal value noise height block.
// Depends on fvnh_pkg and the RTL top fractal_value_noise_height.
`timescale 1ns / 1ps
module tb import fvnh_pkg::*; ();

  localparam longint OneQL   = 64'sd1 << 16;
  localparam longint Rcp320  = ((64'sd1 << 32) + 160) / 320;
  localparam longint WgtO0   = (6 * OneQL + 5) / 10;
  localparam longint WgtO1   = OneQL / 4;
  localparam longint WgtO2   = (OneQL + 5) / 10;
  localparam longint WgtO3   = (OneQL + 10) / 20;
  localparam longint QDamp   = (7 * OneQL + 5) / 10;
  localparam longint QBias   = (11 * OneQL + 10) / 20;
  localparam int     SettleCy = 12;     // latency plus margin
  localparam int     LimitCy  = 400000;

  typedef struct packed {
    logic       shore;
    logic [6:0] top;
  } column_t;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [47:0] s_axis_tdata;   // world_x[23:0], world_z[47:24]
  logic        m_axis_tvalid, m_axis_tready;
  logic [7:0]  m_axis_tdata;   // top_height[6:0], shore[7]
  logic        cfg_valid_i, cfg_ready_o, cfg_index_i;
  logic [31:0] cfg_data_i;

  fractal_value_noise_height i_dut (.*);

  // predictor copy of the registers
  logic [31:0] seed_q;
  logic        natural_q;

  logic [47:0] coord_q[$];    // columns waiting to be sent
  column_t     height_q[$];   // heights still owed by the block
  int          err_cnt;
  int unsigned cyc;
  logic        took;
  int          burst_left, gap_left, stall_mode, stall_left;
  longint      walk_x, walk_z;

  // ---------------------------------------------------------------- predictor
  function automatic longint lattice(longint x, longint z, logic [31:0] s);
    logic [31:0] h;
    h = x[31:0] * 32'd1619 + z[31:0] * 32'd31337 + s * 32'h9E3779B9;
    h = h ^ (h >> 16);
    h = h * 32'h045d9f3b;
    h = h ^ (h >> 16);
    return longint'(h[15:0]);
  endfunction

  function automatic longint smooth(longint t);
    longint t2;
    t2 = (t * t) >>> 16;
    return (t2 * (3 * OneQL - 2 * t)) >>> 16;
  endfunction

  function automatic longint blend(longint a, longint b, longint f);
    return a + ((f * (b - a)) >>> 16);
  endfunction

  function automatic longint grid_noise(longint qx, longint qz, logic [31:0] s);
    longint x0, z0, fx, fz, a, b;
    x0 = qx >>> 16;
    z0 = qz >>> 16;
    fx = smooth(qx & (OneQL - 1));
    fz = smooth(qz & (OneQL - 1));
    a  = blend(lattice(x0, z0, s), lattice(x0 + 1, z0, s), fx);
    b  = blend(lattice(x0, z0 + 1, s), lattice(x0 + 1, z0 + 1, s), fx);
    return blend(a, b, fz);
  endfunction

  function automatic column_t column_height(logic [47:0] d);
    longint x, z, acc, h, cont, e, t, top, tr;
    column_t r;
    x = longint'($signed(d[23:0]));
    z = longint'($signed(d[47:24]));
    acc = grid_noise(x << 10, z << 10, seed_q) * WgtO0
        + grid_noise(x << 11, z << 11, seed_q) * WgtO1
        + grid_noise(x << 12, z << 12, seed_q) * WgtO2
        + grid_noise(x << 13, z << 13, seed_q) * WgtO3;
    h = acc >>> 16;
    if (natural_q) begin
      cont = grid_noise((x * Rcp320) >>> 16, (z * Rcp320) >>> 16, seed_q + 32'd101);
      e = 2 * cont - QBias;
      if (e < 0) e = (e * QDamp) >>> 16;
      t = e * 26 + (h - OneQL / 2) * 20;
      tr = (t >= 0) ? (t >>> 16) : -((-t) >>> 16);   // toward zero
      top = SeaLevel + tr;
      if (top < 8) top = 8;
      if (top > 120) top = 120;
    end else begin
      top = 60 + ((h * 24) >>> 16);
      if (top < 0) top = 0;
      if (top > 127) top = 127;
    end
    r.top   = top[6:0];
    r.shore = (top <= SeaLevel + 1);
    return r;
  endfunction

  // ---------------------------------------------------------------- clock, limit
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > LimitCy) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driver
  // bursts of columns with random gaps; a held transaction stays until taken
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || took)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (coord_q.size() > 0) begin
        s_axis_tdata  <= coord_q.pop_front();
        s_axis_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver back pressure: always ready, random, or periodic on/off stretches
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 9) < 7);
      default: m_axis_tready <= ((stall_left % 16) < 9);
    endcase
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    column_t got, want;
    took <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegSeed) seed_q <= cfg_data_i;
        else natural_q <= cfg_data_i[0];
      end
      if (s_axis_tvalid && s_axis_tready) height_q.push_back(column_height(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = column_t'(m_axis_tdata);
        if (height_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected transaction, actual top %0d shore %0d",
                   $time, got.top, got.shore);
        end else begin
          want = height_q.pop_front();
          if (got.top !== want.top) begin
            err_cnt++;
            $display("%0t: top_height expected %0d actual %0d", $time, want.top, got.top);
          end
          if (got.shore !== want.shore) begin
            err_cnt++;
            $display("%0t: shore expected %0d actual %0d", $time, want.shore, got.shore);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain;
    while (coord_q.size() > 0 || s_axis_tvalid || height_q.size() > 0) @(posedge clk_i);
    repeat (SettleCy) @(posedge clk_i);
  endtask

  function automatic logic [47:0] pack_xz(longint x, longint z);
    return {z[23:0], x[23:0]};
  endfunction

  task automatic push_directed;
    longint pts[$];
    pts = '{0, 0, 8388607, 8388607, -8388608, -8388608, -8388608, 8388607,
            8388607, -8388608, -1, -1, 63, 64, -64, -65, 319, 320, -320, -321,
            1, -1, 6400, -6400};
    for (int i = 0; i < pts.size(); i += 2) coord_q.push_back(pack_xz(pts[i], pts[i + 1]));
  endtask

  // half contiguous walks (real terrain access), rest full-range noise or near 320/64 grid lines
  task automatic push_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: coord_q.push_back(48'({$urandom(), $urandom()}));
        1: coord_q.push_back(pack_xz(320 * longint'($signed(12'($urandom())))
                                     + $urandom_range(0, 2) - 1,
                                     64 * longint'($signed(14'($urandom())))
                                     + $urandom_range(0, 2) - 1));
        default: begin
          if ($urandom_range(0, 30) == 0) begin
            walk_x = longint'($signed(16'($urandom())));
            walk_z = longint'($signed(16'($urandom())));
          end
          walk_x += $urandom_range(0, 3);
          walk_z += $urandom_range(0, 2) - 1;
          coord_q.push_back(pack_xz(walk_x, walk_z));
        end
      endcase
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegSeed;
    cfg_data_i  = '0;
    seed_q = '0;
    natural_q = 1'b1;
    err_cnt = 0;
    cyc = 0;
    took = 1'b0;
    burst_left = 0; gap_left = 0; stall_mode = 0; stall_left = 0;
    walk_x = 0; walk_z = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings first
    push_directed();
    push_random(300);
    drain();

    write_reg(RegSeed, 32'hFFFF_FFFF);
    push_directed();
    push_random(300);
    drain();

    write_reg(RegMode, 1'b0);   // flat terrain
    write_reg(RegSeed, $urandom());
    push_directed();
    push_random(300);
    drain();

    write_reg(RegSeed, 32'h0);
    push_random(250);
    drain();

    write_reg(RegMode, 1'b1);
    write_reg(RegSeed, $urandom());
    push_random(300);
    drain();

    write_reg(RegSeed, 32'd1);
    push_random(300);
    drain();

    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl
rtl/fvnh_pkg.sv
rtl/fvnh_noise.sv
rtl/fractal_value_noise_height.sv
tb/sv/tb.sv
